### design/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Types and constants shared by the letterbox pointer mapper modules.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int unsigned C_SIDE_W  = 14;
    localparam int unsigned C_PROD_W  = 2 * C_SIDE_W;
    localparam int unsigned C_INDEX_W = 8;

    localparam logic [C_SIDE_W-1:0] C_MAX_SIDE = 14'd16383;

    localparam logic [C_INDEX_W-1:0] C_REG_WINDOW_WIDTH  = 8'd0;
    localparam logic [C_INDEX_W-1:0] C_REG_WINDOW_HEIGHT = 8'd1;
    localparam logic [C_INDEX_W-1:0] C_REG_FRAME_WIDTH   = 8'd2;
    localparam logic [C_INDEX_W-1:0] C_REG_FRAME_HEIGHT  = 8'd3;

    localparam logic [1:0] C_ST_MAPPED  = 2'd0;
    localparam logic [1:0] C_ST_OUTSIDE = 2'd1;
    localparam logic [1:0] C_ST_ZERO    = 2'd2;

    typedef struct packed {
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
    } t_in;

    typedef struct packed {
        logic [C_SIDE_W-1:0] frame_x;
        logic [C_SIDE_W-1:0] frame_y;
        logic [1:0]          map_status;
    } t_out;

    typedef struct packed {
        logic                busy;
        logic                zero;
        logic [C_SIDE_W-1:0] left;
        logic [C_SIDE_W-1:0] top;
        logic [C_SIDE_W-1:0] pic_w;
        logic [C_SIDE_W-1:0] pic_h;
        logic [C_SIDE_W-1:0] frame_w;
        logic [C_SIDE_W-1:0] frame_h;
    } t_geom;

endpackage

### design/lpm_div_stage.sv
// ----------------------------------------------------------------------------
// lpm_div_stage
// One registered stage of the per-axis restoring divider, two quotient bits.
// ----------------------------------------------------------------------------
module lpm_div_stage
    import lpm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [C_SIDE_W-1:0] i_den,
    input  logic [C_SIDE_W-1:0] i_rem,
    input  logic [C_SIDE_W-1:0] i_work,
    output logic [C_SIDE_W-1:0] o_den,
    output logic [C_SIDE_W-1:0] o_rem,
    output logic [C_SIDE_W-1:0] o_work
);

    logic [C_SIDE_W-1:0] r_den, r_rem, r_work;
    logic [C_SIDE_W-1:0] n_rem, n_work;

    always_comb begin
        logic [C_SIDE_W:0] t;
        n_rem  = i_rem;
        n_work = i_work;
        for (int s = 0; s < 2; s++) begin
            t      = {n_rem, n_work[C_SIDE_W-1]};
            n_work = {n_work[C_SIDE_W-2:0], 1'b0};
            if (t >= {1'b0, i_den}) begin
                t         = t - {1'b0, i_den};
                n_work[0] = 1'b1;
            end
            n_rem = t[C_SIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_work = r_work;

endmodule

### design/lpm_geometry.sv
// ----------------------------------------------------------------------------
// lpm_geometry
// Configuration registers and the sequential picture fit (one bit per cycle).
// ----------------------------------------------------------------------------
module lpm_geometry
    import lpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [C_INDEX_W-1:0] i_cfg_index,
    input  logic [C_SIDE_W-1:0]  i_cfg_data,
    output t_geom                o_geom
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CMP  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIT  = 5'b10000
    } t_state;

    localparam int unsigned C_NUM_W = C_PROD_W + 1;

    t_state              r_state;
    logic [C_SIDE_W-1:0] r_cw, r_ch, r_fw, r_fh;
    logic [C_PROD_W-1:0] r_p1, r_p2;
    logic                r_wfit, r_zero;
    logic [C_NUM_W-1:0]  r_num;
    logic [C_SIDE_W+1:0] r_rem;
    logic [C_SIDE_W:0]   r_den;
    logic [4:0]          r_cnt;
    logic [C_SIDE_W-1:0] r_left, r_top, r_pw, r_ph;
    logic [C_SIDE_W-1:0] w_val;
    logic [C_SIDE_W+1:0] w_t;
    logic                w_ge;
    logic [C_SIDE_W:0]   w_q;
    logic [C_SIDE_W-1:0] w_lim, w_side, w_pw, w_ph;

    assign w_val = (i_cfg_data > C_MAX_SIDE) ? C_MAX_SIDE : i_cfg_data;
    assign w_t   = {r_rem[C_SIDE_W:0], r_num[C_NUM_W-1]};
    assign w_ge  = w_t >= {1'b0, r_den};
    assign w_q   = r_num[C_SIDE_W:0];
    assign w_lim = r_wfit ? r_ch : r_cw;

    always_comb begin
        if (w_q == '0) begin
            w_side = 14'd1;
        end else if (w_q > {1'b0, w_lim}) begin
            w_side = w_lim;
        end else begin
            w_side = w_q[C_SIDE_W-1:0];
        end
        w_pw = r_wfit ? r_cw : w_side;
        w_ph = r_wfit ? w_side : r_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cw    <= '0;
            r_ch    <= '0;
            r_fw    <= '0;
            r_fh    <= '0;
            r_zero  <= 1'b1;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    C_REG_WINDOW_WIDTH:  r_cw <= w_val;
                    C_REG_WINDOW_HEIGHT: r_ch <= w_val;
                    C_REG_FRAME_WIDTH:   r_fw <= w_val;
                    C_REG_FRAME_HEIGHT:  r_fh <= w_val;
                    default: ;
                endcase
                r_state <= S_MUL;
            end else begin
                case (r_state)
                    S_IDLE: ;
                    S_MUL: begin
                        r_p1    <= r_cw * r_fh;
                        r_p2    <= r_ch * r_fw;
                        r_zero  <= (r_cw == '0) || (r_ch == '0) || (r_fw == '0) ||
                                   (r_fh == '0);
                        r_state <= S_CMP;
                    end
                    S_CMP: begin
                        r_wfit <= r_p1 <= r_p2;
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        if (r_p1 <= r_p2) begin
                            r_num <= {r_p1, 1'b0} + {15'd0, r_fw};
                            r_den <= {r_fw, 1'b0};
                        end else begin
                            r_num <= {r_p2, 1'b0} + {15'd0, r_fh};
                            r_den <= {r_fh, 1'b0};
                        end
                        r_state <= r_zero ? S_IDLE : S_DIV;
                    end
                    S_DIV: begin
                        r_rem <= w_ge ? w_t - {1'b0, r_den} : w_t;
                        r_num <= {r_num[C_NUM_W-2:0], w_ge};
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'(C_NUM_W - 1)) begin
                            r_state <= S_FIT;
                        end
                    end
                    S_FIT: begin
                        r_pw    <= w_pw;
                        r_ph    <= w_ph;
                        r_left  <= 14'((r_cw - w_pw) >> 1);
                        r_top   <= 14'((r_ch - w_ph) >> 1);
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_geom.busy    = r_state != S_IDLE;
        o_geom.zero    = r_zero;
        o_geom.left    = r_left;
        o_geom.top     = r_top;
        o_geom.pic_w   = r_pw;
        o_geom.pic_h   = r_ph;
        o_geom.frame_w = r_fw;
        o_geom.frame_h = r_fh;
    end

`ifndef SYNTH
    a_fit_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_zero) |-> (r_pw <= r_cw && r_ph <= r_ch && r_pw != '0))
        else $error("picture exceeds window");
    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_state == S_MUL)
        else $error("configuration write did not restart fit");
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < 5'(C_NUM_W))
        else $error("fit divider overran");
`endif

endmodule

### design/letterbox_pointer_mapper.sv
// ----------------------------------------------------------------------------
// letterbox_pointer_mapper
// Maps window pointer positions onto a letterboxed remote framebuffer.
// ----------------------------------------------------------------------------
// Usage: write window_width, window_height, frame_width, frame_height through
// the configuration channel (index 0..3, o_cfg_ready is always high). After
// each write the fit unit computes the picture size with a one-bit-per-cycle
// divider, during which o_in_stall is high. Pointer transactions then enter
// on the input channel one per cycle while o_in_stall is low, each producing
// exactly one result, passing the input register, offset and bounds check,
// 14x14 multiply, seven two-bit divider stages, output register. Throughput
// is one transaction per cycle when nothing stalls. When the receiver stalls,
// results hold in their stages; empty stages keep filling, and input stalls
// only once the pipeline is full or the fit unit is busy. Synchronous
// active-low reset empties the pipeline and clears the window and frame
// sizes, so results report a zero size until the registers are written.
// ----------------------------------------------------------------------------
module letterbox_pointer_mapper
    import lpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [C_INDEX_W-1:0] i_cfg_index,
    input  logic [C_SIDE_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data
);

    localparam int unsigned C_DIV_ST = 7;
    localparam int unsigned C_NST    = C_DIV_ST + 4;
    localparam int unsigned C_LAST   = C_NST - 1;

    t_geom               w_geom;
    logic [C_NST-1:0]    r_v;
    logic [C_NST:0]      w_acc;
    logic [1:0]          r_st [1:C_LAST-1];
    t_in                 r_in;
    logic [C_SIDE_W-1:0] r_dx, r_dy;
    logic [C_PROD_W-1:0] r_nx, r_ny;
    logic [C_SIDE_W-1:0] w_den_x [C_DIV_ST+1];
    logic [C_SIDE_W-1:0] w_rem_x [C_DIV_ST+1];
    logic [C_SIDE_W-1:0] w_wrk_x [C_DIV_ST+1];
    logic [C_SIDE_W-1:0] w_den_y [C_DIV_ST+1];
    logic [C_SIDE_W-1:0] w_rem_y [C_DIV_ST+1];
    logic [C_SIDE_W-1:0] w_wrk_y [C_DIV_ST+1];
    logic signed [16:0]  w_sx, w_sy;
    logic                w_in_x, w_in_y;
    logic [C_SIDE_W-1:0] w_qx, w_qy;
    t_out                r_out;

    lpm_geometry u_geometry (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom)
    );

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_acc[C_NST] = !i_out_stall;
        for (int k = C_NST - 1; k >= 0; k--) begin
            w_acc[k] = !r_v[k] || w_acc[k+1];
        end
    end

    assign o_in_stall = !w_acc[0] || w_geom.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_acc[0]) begin
                r_v[0] <= i_in_valid && !w_geom.busy;
            end
            for (int k = 1; k < C_NST; k++) begin
                if (w_acc[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_sx   = {r_in.pointer_x[15], r_in.pointer_x} - $signed({3'b000, w_geom.left});
    assign w_sy   = {r_in.pointer_y[15], r_in.pointer_y} - $signed({3'b000, w_geom.top});
    assign w_in_x = !w_sx[16] && (w_sx[15:0] < {2'b00, w_geom.pic_w});
    assign w_in_y = !w_sy[16] && (w_sy[15:0] < {2'b00, w_geom.pic_h});

    always_ff @(posedge i_clk) begin
        if (w_acc[0]) begin
            r_in <= i_in_data;
        end
        if (w_acc[1]) begin
            if (w_geom.zero) begin
                r_st[1] <= C_ST_ZERO;
            end else if (!(w_in_x && w_in_y)) begin
                r_st[1] <= C_ST_OUTSIDE;
            end else begin
                r_st[1] <= C_ST_MAPPED;
            end
            r_dx <= (w_in_x && w_in_y) ? w_sx[C_SIDE_W-1:0] : '0;
            r_dy <= (w_in_x && w_in_y) ? w_sy[C_SIDE_W-1:0] : '0;
        end
        if (w_acc[2]) begin
            r_st[2] <= r_st[1];
            r_nx    <= r_dx * w_geom.frame_w;
            r_ny    <= r_dy * w_geom.frame_h;
        end
        for (int k = 3; k < C_LAST; k++) begin
            if (w_acc[k]) begin
                r_st[k] <= r_st[k-1];
            end
        end
    end

    assign w_den_x[0] = w_geom.pic_w;
    assign w_rem_x[0] = r_nx[C_PROD_W-1:C_SIDE_W];
    assign w_wrk_x[0] = r_nx[C_SIDE_W-1:0];
    assign w_den_y[0] = w_geom.pic_h;
    assign w_rem_y[0] = r_ny[C_PROD_W-1:C_SIDE_W];
    assign w_wrk_y[0] = r_ny[C_SIDE_W-1:0];

    for (genvar j = 0; j < C_DIV_ST; j++) begin : g_div
        lpm_div_stage u_div_x (
            .i_clk  (i_clk),
            .i_en   (w_acc[j+3]),
            .i_den  (w_den_x[j]),
            .i_rem  (w_rem_x[j]),
            .i_work (w_wrk_x[j]),
            .o_den  (w_den_x[j+1]),
            .o_rem  (w_rem_x[j+1]),
            .o_work (w_wrk_x[j+1])
        );
        lpm_div_stage u_div_y (
            .i_clk  (i_clk),
            .i_en   (w_acc[j+3]),
            .i_den  (w_den_y[j]),
            .i_rem  (w_rem_y[j]),
            .i_work (w_wrk_y[j]),
            .o_den  (w_den_y[j+1]),
            .o_rem  (w_rem_y[j+1]),
            .o_work (w_wrk_y[j+1])
        );
    end

    assign w_qx = (w_wrk_x[C_DIV_ST] >= w_geom.frame_w) ? w_geom.frame_w - 14'd1
                                                        : w_wrk_x[C_DIV_ST];
    assign w_qy = (w_wrk_y[C_DIV_ST] >= w_geom.frame_h) ? w_geom.frame_h - 14'd1
                                                        : w_wrk_y[C_DIV_ST];

    always_ff @(posedge i_clk) begin
        if (w_acc[C_LAST]) begin
            r_out.map_status <= r_st[C_LAST-1];
            r_out.frame_x    <= (r_st[C_LAST-1] == C_ST_MAPPED) ? w_qx : '0;
            r_out.frame_y    <= (r_st[C_LAST-1] == C_ST_MAPPED) ? w_qy : '0;
        end
    end

    assign o_out_valid = r_v[C_LAST];
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_no_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !w_geom.busy)
        else $error("transaction accepted during fit");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.map_status == C_ST_MAPPED ||
                         o_out_data.map_status == C_ST_OUTSIDE ||
                         o_out_data.map_status == C_ST_ZERO))
        else $error("bad status code");
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.map_status != C_ST_MAPPED) |->
        (o_out_data.frame_x == '0 && o_out_data.frame_y == '0))
        else $error("unmapped result carries coordinates");
    a_mapped_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.map_status == C_ST_MAPPED) |->
        (o_out_data.frame_x < w_geom.frame_w && o_out_data.frame_y < w_geom.frame_h))
        else $error("mapped result outside framebuffer");
`endif

endmodule
